FILE: hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// Implication whose consequent is checked at the next rising clock edge.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

FILE: hdl/bia_pkg.sv
// Package with opcodes, error codes and shared types of the integer ALU.
`timescale 1ns / 1ps
package bia_pkg;
    localparam int DataWidthDefault = 32;
    localparam int FieldBits = 32;

    typedef enum logic [4:0] {
        OP_ADD = 5'd0, OP_SUB = 5'd1, OP_MUL = 5'd2, OP_DIV = 5'd3, OP_MOD = 5'd4,
        OP_POW = 5'd5, OP_EQ = 5'd6, OP_LT = 5'd7, OP_GT = 5'd8, OP_LE = 5'd9,
        OP_GE = 5'd10, OP_NE = 5'd11, OP_AND = 5'd12, OP_OR = 5'd13, OP_NOT = 5'd14,
        OP_NEG = 5'd15, OP_ABS = 5'd16, OP_SGN = 5'd17, OP_SQRT = 5'd18
    } op_t;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_DIV0 = 2'd1;
    localparam logic [1:0] ERR_ILLQ = 2'd2;

    // Which serial unit an item goes to.
    typedef enum logic [1:0] {
        UNIT_MUL = 2'd0,
        UNIT_DIV = 2'd1,
        UNIT_SQRT = 2'd2
    } unit_t;

    typedef struct packed {
        logic start;
        unit_t unit;
    } ctl_t;
endpackage

FILE: hdl/bia_mul.sv
// Shift-and-add multiplier, one multiplier bit per cycle, result modulo 2^W.
`timescale 1ns / 1ps
module bia_mul #(
    parameter int W = bia_pkg::DataWidthDefault
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] mcand,
    input  logic [W-1:0] mplier,
    output logic         done,
    output logic [W-1:0] product
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  a_reg, a_next;
    logic [W-1:0]  b_reg, b_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    always_comb
    begin
        acc_next = acc_reg;
        a_next = a_reg;
        b_next = b_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next = '0;
            a_next = mcand;
            b_next = mplier;
            cnt_next = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
            begin
                acc_next = acc_reg + a_reg;
            end
            a_next = {a_reg[W-2:0], 1'b0};
            b_next = {1'b0, b_reg[W-1:1]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg <= a_next;
        b_reg <= b_next;
    end

    assign done = done_reg;
    assign product = acc_reg;
endmodule

FILE: hdl/bia_div.sv
// Restoring divider on magnitudes, one quotient bit per cycle.
`timescale 1ns / 1ps
module bia_div #(
    parameter int W = bia_pkg::DataWidthDefault
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  q_reg, q_next;
    logic [W-1:0]  r_reg, r_next;
    logic [W-1:0]  d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;
    logic [W:0]    diff;

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {r_reg, q_reg[W-1]};
        diff = trial - {1'b0, d_reg};
        if (start)
        begin
            q_next = dividend;
            r_next = '0;
            d_next = divisor;
            cnt_next = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[W])
            begin
                r_next = diff[W-1:0];
                q_next = {q_reg[W-2:0], 1'b1};
            end
            else
            begin
                r_next = trial[W-1:0];
                q_next = {q_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign quotient = q_reg;
    assign remainder = r_reg;
endmodule

FILE: hdl/bia_sqrt.sv
// Digit-by-digit floor square root, one result bit (two radicand bits) per cycle.
`timescale 1ns / 1ps
module bia_sqrt #(
    parameter int W = bia_pkg::DataWidthDefault
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] radicand,
    output logic         done,
    output logic [W-1:0] root
);
    localparam int H = (W + 1) / 2;
    localparam int XW = 2 * H;
    localparam int CW = $clog2(H + 1);

    logic [XW-1:0] x_reg, x_next;
    logic [H+1:0]  r_reg, r_next;
    logic [H-1:0]  q_reg, q_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [H+1:0]  trial;
    logic [H+1:0]  sub;
    logic [H+2:0]  diff;

    always_comb
    begin
        x_next = x_reg;
        r_next = r_reg;
        q_next = q_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {r_reg[H-1:0], x_reg[XW-1:XW-2]};
        sub = {q_reg, 2'b01};
        diff = {1'b0, trial} - {1'b0, sub};
        if (start)
        begin
            x_next = XW'(radicand);
            r_next = '0;
            q_next = '0;
            cnt_next = CW'(H);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            x_next = {x_reg[XW-3:0], 2'b00};
            if (!diff[H+2])
            begin
                r_next = diff[H+1:0];
                q_next = {q_reg[H-2:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[H-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        r_reg <= r_next;
        q_reg <= q_next;
    end

    assign done = done_reg;
    assign root = W'(q_reg);
endmodule

FILE: hdl/basic_integer_alu_unit.sv
// Top level of the integer ALU: sequencer, simple operations and output register.
//
//  channel | signals                                          | direction
//  in      | in_valid, in_ready, op, operand_a, operand_b      | item in
//  out     | out_valid, out_ready, value, error_code           | result out
//
// Simple operations are computed in S_DEC and registered into the output register.
// Multiply, divide and modulo run on the bit-serial units; divide and modulo by zero or -1 are settled in S_DEC.
// Power steps through the W exponent bits: per exponent bit a multiply if the bit is set, then a squaring.
// Square root runs on the bit-serial unit. One item is in work at a time.
// A result waits in the output register while out_ready is low.
// Reset is asynchronous and clears all control state.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module basic_integer_alu_unit #(
    parameter int DATA_WIDTH = bia_pkg::DataWidthDefault
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [4:0]         op,
    input  logic signed [31:0] operand_a,
    input  logic signed [31:0] operand_b,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] value,
    output logic [1:0]         error_code
);
    localparam int W = DATA_WIDTH;
    localparam int CW = $clog2(W + 1);
    localparam int FB = bia_pkg::FieldBits;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_DEC = 7'b0000010,
        S_WAIT = 7'b0000100,
        S_PMUL = 7'b0001000,
        S_PSQ = 7'b0010000,
        S_OUT = 7'b0100000,
        S_PSTEP = 7'b1000000
    } state_t;

    state_t        state_reg, state_next;
    logic [4:0]    op_reg, op_next;
    logic [W-1:0]  a_reg, a_next;
    logic [W-1:0]  b_reg, b_next;
    logic [W-1:0]  res_reg, res_next;
    logic [1:0]    err_reg, err_next;
    logic [W-1:0]  pr_reg, pr_next;
    logic [W-1:0]  pb_reg, pb_next;
    logic [W-1:0]  pe_reg, pe_next;
    logic [CW-1:0] pc_reg, pc_next;
    logic          ov_reg, ov_next;

    logic [W-1:0]  a_in, b_in;
    logic          an, bn;
    logic [W-1:0]  abs_a, abs_b;
    logic [W-1:0]  ones;
    logic          slt_ab, slt_ba;
    bia_pkg::ctl_t ctl;
    logic [W-1:0]  mul_x, mul_y, mul_p, q, r, rt;
    logic          mul_done, div_done, sq_done;

    // Sign-extend or truncate each 32-bit field to the working width.
    assign a_in = W'(signed'(operand_a));
    assign b_in = W'(signed'(operand_b));

    assign ones = '1;
    assign an = a_reg[W-1];
    assign bn = b_reg[W-1];
    assign abs_a = an ? (~a_reg + 1'b1) : a_reg;
    assign abs_b = bn ? (~b_reg + 1'b1) : b_reg;
    assign slt_ab = $signed(a_reg) < $signed(b_reg);
    assign slt_ba = $signed(b_reg) < $signed(a_reg);

    bia_mul #(.W(W)) u_mul (
        .clk(clk), .rst_n(rst_n),
        .start(ctl.start && ctl.unit == bia_pkg::UNIT_MUL),
        .mcand(mul_x), .mplier(mul_y), .done(mul_done), .product(mul_p)
    );
    bia_div #(.W(W)) u_div (
        .clk(clk), .rst_n(rst_n),
        .start(ctl.start && ctl.unit == bia_pkg::UNIT_DIV),
        .dividend(abs_a), .divisor(abs_b), .done(div_done),
        .quotient(q), .remainder(r)
    );
    bia_sqrt #(.W(W)) u_sqrt (
        .clk(clk), .rst_n(rst_n),
        .start(ctl.start && ctl.unit == bia_pkg::UNIT_SQRT),
        .radicand(a_reg), .done(sq_done), .root(rt)
    );

    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        a_next = a_reg;
        b_next = b_reg;
        res_next = res_reg;
        err_next = err_reg;
        pr_next = pr_reg;
        pb_next = pb_reg;
        pe_next = pe_reg;
        pc_next = pc_reg;
        ov_next = ov_reg;
        ctl.start = 1'b0;
        ctl.unit = bia_pkg::UNIT_MUL;
        mul_x = a_reg;
        mul_y = b_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next = op;
                    a_next = a_in;
                    b_next = b_in;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                res_next = '0;
                err_next = bia_pkg::ERR_NONE;
                state_next = S_OUT;
                case (op_reg)
                    bia_pkg::OP_ADD: res_next = a_reg + b_reg;
                    bia_pkg::OP_SUB: res_next = a_reg - b_reg;
                    bia_pkg::OP_MUL:
                    begin
                        ctl.start = 1'b1;
                        state_next = S_WAIT;
                    end
                    bia_pkg::OP_DIV, bia_pkg::OP_MOD:
                    begin
                        if (b_reg == '0)
                        begin
                            err_next = bia_pkg::ERR_DIV0;
                        end
                        else if (b_reg == ones)
                        begin
                            res_next = (op_reg == bia_pkg::OP_DIV) ? (~a_reg + 1'b1) : '0;
                        end
                        else
                        begin
                            ctl.start = 1'b1;
                            ctl.unit = bia_pkg::UNIT_DIV;
                            state_next = S_WAIT;
                        end
                    end
                    bia_pkg::OP_POW:
                    begin
                        if (bn)
                        begin
                            if (a_reg == '0)
                            begin
                                err_next = bia_pkg::ERR_DIV0;
                            end
                            else if (a_reg == W'(1))
                            begin
                                res_next = W'(1);
                            end
                            else if (a_reg == ones)
                            begin
                                res_next = b_reg[0] ? ones : W'(1);
                            end
                        end
                        else
                        begin
                            pr_next = W'(1);
                            pb_next = a_reg;
                            pe_next = b_reg;
                            pc_next = CW'(W);
                            state_next = S_PSTEP;
                        end
                    end
                    bia_pkg::OP_EQ: res_next = W'(a_reg == b_reg);
                    bia_pkg::OP_LT: res_next = W'(slt_ab);
                    bia_pkg::OP_GT: res_next = W'(slt_ba);
                    bia_pkg::OP_LE: res_next = W'(!slt_ba);
                    bia_pkg::OP_GE: res_next = W'(!slt_ab);
                    bia_pkg::OP_NE: res_next = W'(a_reg != b_reg);
                    bia_pkg::OP_AND: res_next = W'(a_reg != '0 && b_reg != '0);
                    bia_pkg::OP_OR: res_next = W'(a_reg != '0 || b_reg != '0);
                    bia_pkg::OP_NOT: res_next = W'(a_reg == '0);
                    bia_pkg::OP_NEG: res_next = ~a_reg + 1'b1;
                    bia_pkg::OP_ABS: res_next = abs_a;
                    bia_pkg::OP_SGN: res_next = an ? ones : W'(a_reg != '0);
                    bia_pkg::OP_SQRT:
                    begin
                        if (an)
                        begin
                            err_next = bia_pkg::ERR_ILLQ;
                        end
                        else
                        begin
                            ctl.start = 1'b1;
                            ctl.unit = bia_pkg::UNIT_SQRT;
                            state_next = S_WAIT;
                        end
                    end
                    default: res_next = '0;
                endcase
            end
            S_WAIT:
            begin
                if (mul_done)
                begin
                    res_next = mul_p;
                    state_next = S_OUT;
                end
                else if (div_done)
                begin
                    if (op_reg == bia_pkg::OP_DIV)
                    begin
                        res_next = (an != bn) ? (~q + 1'b1) : q;
                    end
                    else
                    begin
                        res_next = an ? (~r + 1'b1) : r;
                    end
                    state_next = S_OUT;
                end
                else if (sq_done)
                begin
                    res_next = rt;
                    state_next = S_OUT;
                end
            end
            // One exponent bit per step: multiply into the result if set, then square; after the last bit, output.
            S_PSTEP:
            begin
                if (pc_reg == '0)
                begin
                    res_next = pr_reg;
                    state_next = S_OUT;
                end
                else if (pe_reg[0])
                begin
                    mul_x = pr_reg;
                    mul_y = pb_reg;
                    ctl.start = 1'b1;
                    state_next = S_PMUL;
                end
                else
                begin
                    mul_x = pb_reg;
                    mul_y = pb_reg;
                    ctl.start = 1'b1;
                    state_next = S_PSQ;
                end
            end
            S_PMUL:
            begin
                if (mul_done)
                begin
                    pr_next = mul_p;
                    mul_x = pb_reg;
                    mul_y = pb_reg;
                    ctl.start = 1'b1;
                    state_next = S_PSQ;
                end
            end
            S_PSQ:
            begin
                if (mul_done)
                begin
                    pb_next = mul_p;
                    pe_next = {1'b0, pe_reg[W-1:1]};
                    pc_next = pc_reg - 1'b1;
                    state_next = S_PSTEP;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        ov_next = (state_next == S_OUT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg <= 1'b0;
            pc_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg <= ov_next;
            pc_reg <= pc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        a_reg <= a_next;
        b_reg <= b_next;
        res_reg <= res_next;
        err_reg <= err_next;
        pr_reg <= pr_next;
        pb_reg <= pb_next;
        pe_reg <= pe_next;
    end

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = ov_reg;
    assign error_code = err_reg;
    assign value = FB'(signed'(res_reg));

    `ASSERT_IMPL(a_valid_state, clk, rst_n, out_valid, state_reg == S_OUT)
    `ASSERT_IMPL(a_no_overlap, clk, rst_n, out_valid, !in_ready)
    `ASSERT_IMPL(a_err_zero, clk, rst_n, out_valid && error_code != bia_pkg::ERR_NONE, value == '0)
    `ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid)
endmodule

FILE: tb/basic_integer_alu_unit_tb.sv
// Self-checking testbench for the integer ALU: directed table, then random operations.
`timescale 1ns / 1ps
module basic_integer_alu_unit_tb;

    typedef struct {
        logic [4:0]  op;
        logic [31:0] a;
        logic [31:0] b;
        bit          known;
        logic [31:0] value;
        logic [1:0]  err;
    } alu_row_t;

    typedef struct {
        logic [31:0] value;
        logic [1:0]  err;
    } alu_res_t;

    localparam logic [31:0] MaxPos = 32'h7fff_ffff;
    localparam logic [31:0] MinNeg = 32'h8000_0000;
    localparam logic [31:0] AllOnes = 32'hffff_ffff;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [4:0] op = '0;
    logic signed [31:0] operand_a = '0;
    logic signed [31:0] operand_b = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [31:0] value;
    logic [1:0] error_code;

    alu_res_t pending_results[$];
    alu_row_t items_to_send[$];
    int mismatches = 0;
    bit stimulus_done = 1'b0;
    bit long_hold = 1'b0;

    basic_integer_alu_unit i_dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready), .op(op),
        .operand_a(operand_a), .operand_b(operand_b), .out_valid(out_valid),
        .out_ready(out_ready), .value(value), .error_code(error_code)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [31:0] isqrt(logic [31:0] n);
        logic [31:0] root;
        logic [31:0] rem;
        logic [31:0] bitv;
        root = 0;
        rem = n;
        bitv = 32'h4000_0000;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (rem >= root + bitv)
            begin
                rem = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic alu_res_t alu_compute(logic [4:0] code, logic [31:0] a, logic [31:0] b);
        alu_res_t r;
        logic signed [31:0] sa;
        logic signed [31:0] sb;
        logic [31:0] ua;
        logic [31:0] ub;
        logic [31:0] q;
        logic [31:0] acc;
        logic [31:0] sq;
        sa = a;
        sb = b;
        ua = a[31] ? -a : a;
        ub = b[31] ? -b : b;
        r.value = 0;
        r.err = bia_pkg::ERR_NONE;
        case (code)
            bia_pkg::OP_ADD: r.value = a + b;
            bia_pkg::OP_SUB: r.value = a - b;
            bia_pkg::OP_MUL: r.value = a * b;
            bia_pkg::OP_DIV:
                if (b == 0) r.err = bia_pkg::ERR_DIV0;
                else if (b == AllOnes) r.value = -a;
                else
                begin
                    q = ua / ub;
                    r.value = (a[31] != b[31]) ? -q : q;
                end
            bia_pkg::OP_MOD:
                if (b == 0) r.err = bia_pkg::ERR_DIV0;
                else if (b == AllOnes) r.value = 0;
                else
                begin
                    q = ua % ub;
                    r.value = a[31] ? -q : q;
                end
            bia_pkg::OP_POW:
                if (b[31])
                begin
                    if (a == 0) r.err = bia_pkg::ERR_DIV0;
                    else if (a == 1) r.value = 1;
                    else if (a == AllOnes) r.value = b[0] ? AllOnes : 1;
                    else r.value = 0;
                end
                else
                begin
                    acc = 1;
                    sq = a;
                    for (int i = 0; i < 32; i++)
                    begin
                        if (b[i]) acc = acc * sq;
                        sq = sq * sq;
                    end
                    r.value = acc;
                end
            bia_pkg::OP_EQ: r.value = (a == b);
            bia_pkg::OP_LT: r.value = (sa < sb);
            bia_pkg::OP_GT: r.value = (sa > sb);
            bia_pkg::OP_LE: r.value = (sa <= sb);
            bia_pkg::OP_GE: r.value = (sa >= sb);
            bia_pkg::OP_NE: r.value = (a != b);
            bia_pkg::OP_AND: r.value = (a != 0 && b != 0);
            bia_pkg::OP_OR: r.value = (a != 0 || b != 0);
            bia_pkg::OP_NOT: r.value = (a == 0);
            bia_pkg::OP_NEG: r.value = -a;
            bia_pkg::OP_ABS: r.value = ua;
            bia_pkg::OP_SGN: r.value = a[31] ? AllOnes : (a != 0 ? 1 : 0);
            bia_pkg::OP_SQRT:
                if (a[31]) r.err = bia_pkg::ERR_ILLQ;
                else r.value = isqrt(a);
            default: ;
        endcase
        if (r.err != bia_pkg::ERR_NONE)
            r.value = 0;
        return r;
    endfunction

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 7))
            0: return MinNeg;
            1: return MaxPos;
            2: return AllOnes;
            3: return $urandom_range(0, 3);
            4: return 32'($urandom_range(0, 40)) - 20;
            5: return 32'($urandom_range(0, 65535));
            default: return $urandom;
        endcase
    endfunction

    task automatic add_row(logic [4:0] c, logic [31:0] a, logic [31:0] b, bit k,
                           logic [31:0] v, logic [1:0] e);
        alu_row_t row;
        row.op = c;
        row.a = a;
        row.b = b;
        row.known = k;
        row.value = v;
        row.err = e;
        items_to_send.push_back(row);
    endtask

    // Sender: walks the directed table and then the random items.
    initial
    begin
        alu_row_t row;
        alu_res_t exp_res;
        int gap;
        add_row(bia_pkg::OP_ADD, MaxPos, 1, 1, MinNeg, bia_pkg::ERR_NONE);
        add_row(bia_pkg::OP_SUB, MinNeg, 1, 1, MaxPos, bia_pkg::ERR_NONE);
        add_row(bia_pkg::OP_MUL, MinNeg, AllOnes, 1, MinNeg, bia_pkg::ERR_NONE);
        add_row(bia_pkg::OP_DIV, 7, 0, 1, 0, bia_pkg::ERR_DIV0);
        add_row(bia_pkg::OP_MOD, 7, 0, 1, 0, bia_pkg::ERR_DIV0);
        add_row(bia_pkg::OP_DIV, MinNeg, AllOnes, 1, MinNeg, bia_pkg::ERR_NONE);
        add_row(bia_pkg::OP_MOD, MinNeg, AllOnes, 1, 0, bia_pkg::ERR_NONE);
        add_row(bia_pkg::OP_DIV, -7, 2, 0, 0, bia_pkg::ERR_NONE);
        add_row(bia_pkg::OP_MOD, -7, 2, 0, 0, bia_pkg::ERR_NONE);
        add_row(bia_pkg::OP_POW, 0, AllOnes, 1, 0, bia_pkg::ERR_DIV0);
        add_row(bia_pkg::OP_POW, 1, MinNeg, 1, 1, bia_pkg::ERR_NONE);
        add_row(bia_pkg::OP_POW, AllOnes, -3, 1, AllOnes, bia_pkg::ERR_NONE);
        add_row(bia_pkg::OP_POW, AllOnes, -2, 1, 1, bia_pkg::ERR_NONE);
        add_row(bia_pkg::OP_POW, 5, AllOnes, 1, 0, bia_pkg::ERR_NONE);
        add_row(bia_pkg::OP_POW, 0, 0, 1, 1, bia_pkg::ERR_NONE);
        add_row(bia_pkg::OP_POW, 3, MaxPos, 0, 0, bia_pkg::ERR_NONE);
        add_row(bia_pkg::OP_LT, MinNeg, MaxPos, 1, 1, bia_pkg::ERR_NONE);
        add_row(bia_pkg::OP_GE, MinNeg, MaxPos, 1, 0, bia_pkg::ERR_NONE);
        add_row(bia_pkg::OP_NEG, MinNeg, 0, 1, MinNeg, bia_pkg::ERR_NONE);
        add_row(bia_pkg::OP_ABS, MinNeg, 0, 1, MinNeg, bia_pkg::ERR_NONE);
        add_row(bia_pkg::OP_SGN, MinNeg, 0, 1, AllOnes, bia_pkg::ERR_NONE);
        add_row(bia_pkg::OP_SQRT, AllOnes, 0, 1, 0, bia_pkg::ERR_ILLQ);
        add_row(bia_pkg::OP_SQRT, MaxPos, 0, 1, 46340, bia_pkg::ERR_NONE);
        add_row(5'd31, AllOnes, AllOnes, 1, 0, bia_pkg::ERR_NONE);
        for (int c = 6; c <= 14; c++)
            add_row(c[4:0], 0, AllOnes, 0, 0, bia_pkg::ERR_NONE);
        for (int n = 0; n < 750; n++)
        begin
            logic [4:0] c;
            // Power is slow, so keep it rare; opcodes past the table now and then.
            c = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(19, 31))
                                             : 5'($urandom_range(0, 18));
            if (c == bia_pkg::OP_POW && $urandom_range(0, 3) != 0)
                c = bia_pkg::OP_MUL;
            add_row(c, rand_operand(), rand_operand(), 0, 0, bia_pkg::ERR_NONE);
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        foreach (items_to_send[i])
        begin
            row = items_to_send[i];
            gap = (i > 40 && i < 120) ? 0 : $urandom_range(0, 9);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            in_valid <= 1'b1;
            op <= row.op;
            operand_a <= row.a;
            operand_b <= row.b;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            if (row.known)
            begin
                exp_res.value = row.value;
                exp_res.err = row.err;
            end
            else
                exp_res = alu_compute(row.op, row.a, row.b);
            pending_results.push_back(exp_res);
            @(negedge clk);
        end
        in_valid <= 1'b0;
        stimulus_done = 1'b1;
    end

    // Receiver: random stalls, plus one long hold-off early in the run.
    initial
    begin
        int wait_cycles;
        int received;
        received = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!long_hold && received == 30)
            begin
                long_hold = 1'b1;
                out_ready <= 1'b0;
                repeat (300) @(negedge clk);
            end
            wait_cycles = $urandom_range(0, 9);
            if (wait_cycles > 0 && $urandom_range(0, 3) != 0)
            begin
                out_ready <= 1'b0;
                repeat (wait_cycles) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            received++;
        end
    end

    // Checks every result transfer against the oldest expectation.
    always @(posedge clk)
    begin
        alu_res_t exp_res;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result value=%h err=%0d", $time, value, error_code);
                mismatches++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (value !== exp_res.value)
                begin
                    $display("%0t: value expected %h actual %h", $time, exp_res.value, value);
                    mismatches++;
                end
                if (error_code !== exp_res.err)
                begin
                    $display("%0t: error_code expected %0d actual %0d", $time, exp_res.err,
                             error_code);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        wait (stimulus_done);
        wait (pending_results.size() == 0);
        repeat (100) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Power items are slow; this bound leaves wide margin.
    initial
    begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end
endmodule
